>>> rtl/core/bta_pkg.sv
// Shared types and constants of the buddy tree allocator.
package bta_pkg;

  localparam int ORD_W = 5;
  localparam int ORD_IN_W = 4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_BLOCK  = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_ROOT_CHK,
    CMD_DESC_STEP,
    CMD_FREE_CHK,
    CMD_WALK_STEP,
    CMD_EMIT
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic range_bad;
    logic finish;
    logic walk;
  } dp_stat_t;

endpackage

>>> rtl/core/buddy_tree_allocator.sv
// Top level of the buddy tree allocator.
// A binary buddy allocator over a complete tree of 2^(MAX_ORDER+1)-1 nodes, each node
// holding the largest free order of its subtree. After reset the tree store is set to
// all free by a sweep of one node per cycle, during which no request word is taken.
// A request is then accepted, the root or the freed node is checked, the allocation
// descends one level per step, the merge walk climbs one level per step, and the
// result word is loaded; an out-of-range node goes from acceptance straight to the
// result word. The tree store gives two reads and one write per cycle, which serve
// each tree level of the descent and the walk. One request is worked on at a time;
// the next request word can be taken while the previous result word still waits in
// the output register.
module buddy_tree_allocator
  import bta_pkg::*;
#(
  parameter int MAX_ORDER = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic                operation,
  input  logic [MAX_ORDER:0]  search_root,
  input  logic [ORD_IN_W-1:0] block_order,
  input  logic [MAX_ORDER:0]  free_node,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic [MAX_ORDER:0]  node_index,
  output logic [1:0]          status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .operation (operation),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .cmd       (cmd)
  );

  bta_datapath #(
    .MAX_ORDER (MAX_ORDER)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .operation   (operation),
    .search_root (search_root),
    .block_order (block_order),
    .free_node   (free_node),
    .stat        (stat),
    .node_index  (node_index),
    .status      (status)
  );

endmodule

>>> rtl/core/bta_ctrl.sv
// Control state machine of the buddy tree allocator.
module bta_ctrl
  import bta_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     operation,
  input  logic     rsp_ready,
  input  dp_stat_t stat,
  output logic     req_ready,
  output logic     rsp_valid,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ROOT,
    S_DESC,
    S_FCHECK,
    S_WALK,
    S_DONE
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = CMD_NOP;
    rsp_valid_next = rsp_valid & ~rsp_ready;
    unique case (state)
      S_CLEAR: begin
        cmd = CMD_CLEAR;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd = CMD_LOAD;
          if (stat.range_bad) begin
            state_next = S_DONE;
          end else if (operation) begin
            state_next = S_FCHECK;
          end else begin
            state_next = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        cmd = CMD_ROOT_CHK;
        if (stat.finish) begin
          state_next = S_DONE;
        end else if (stat.walk) begin
          state_next = S_WALK;
        end else begin
          state_next = S_DESC;
        end
      end
      S_DESC: begin
        cmd = CMD_DESC_STEP;
        if (stat.finish) begin
          state_next = S_DONE;
        end else if (stat.walk) begin
          state_next = S_WALK;
        end
      end
      S_FCHECK: begin
        cmd = CMD_FREE_CHK;
        if (stat.finish) begin
          state_next = S_DONE;
        end else begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd = CMD_WALK_STEP;
        if (stat.finish) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd = CMD_EMIT;
          rsp_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

>>> rtl/core/bta_datapath.sv
// Datapath of the buddy tree allocator: tree store, walk registers and result word.
module bta_datapath
  import bta_pkg::*;
#(
  parameter int MAX_ORDER = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  input  logic                 operation,
  input  logic [MAX_ORDER:0]   search_root,
  input  logic [ORD_IN_W-1:0]  block_order,
  input  logic [MAX_ORDER:0]   free_node,
  output dp_stat_t             stat,
  output logic [MAX_ORDER:0]   node_index,
  output logic [1:0]           status
);

  localparam int IW = MAX_ORDER + 1;
  localparam int NODES = (2 ** IW) - 1;
  localparam int MEM_DEPTH = 2 ** IW;
  localparam int LEAF_FIRST = (2 ** MAX_ORDER) - 1;

  logic [ORD_W-1:0] mem [MEM_DEPTH];

  logic [IW-1:0]    addr_a, addr_b, wa;
  logic             we;
  logic [ORD_W-1:0] wd, rd_a, rd_b;

  logic [IW-1:0]       idx, idx_next;
  logic [ORD_W-1:0]    lvl, lvl_next;
  logic [ORD_W-1:0]    cur, cur_next;
  logic [ORD_IN_W-1:0] ord, ord_next;
  logic [IW-1:0]       res_node, res_node_next;
  status_t             res_status, res_status_next;
  logic [IW-1:0]       node_q;
  status_t             status_q;

  logic [IW-1:0]    clr_idx, clr_bound;
  logic [ORD_W-1:0] clr_lvl;

  logic             mk_en;
  logic [IW-1:0]    mk_node;
  logic [ORD_W-1:0] mk_val, mk_lvl;
  logic [IW-1:0]    tgt, step_node, par_node;
  logic [ORD_W-1:0] ord_s, pv;

  function automatic logic [ORD_W-1:0] level_of(input logic [IW-1:0] n);
    logic [IW:0]      v;
    logic [ORD_W-1:0] d;
    v = {1'b0, n} + (IW + 1)'(1);
    d = '0;
    for (int i = 1; i <= IW; i++) begin
      if (v[i]) begin
        d = ORD_W'(i);
      end
    end
    return ORD_W'(MAX_ORDER) - d;
  endfunction

  function automatic logic [IW-1:0] lc_of(input logic [IW-1:0] n);
    return IW'({n, 1'b1});
  endfunction

  function automatic logic [IW-1:0] rc_of(input logic [IW-1:0] n);
    return IW'({n, 1'b0} + (IW + 1)'(2));
  endfunction

  function automatic logic [IW-1:0] par_of(input logic [IW-1:0] n);
    return (n - IW'(1)) >> 1;
  endfunction

  function automatic logic [IW-1:0] sib_of(input logic [IW-1:0] n);
    return n[0] ? n + IW'(1) : n - IW'(1);
  endfunction

  function automatic logic is_leaf(input logic [IW-1:0] n);
    return n >= IW'(LEAF_FIRST);
  endfunction

  function automatic logic fits(input logic [ORD_W-1:0] v, input logic [ORD_W-1:0] o);
    return $signed(v) >= $signed(o);
  endfunction

  assign ord_s = {{(ORD_W - ORD_IN_W){1'b0}}, ord};
  assign tgt = operation ? free_node : search_root;
  assign par_node = par_of(idx);

  always_comb begin
    if (cur == lvl && rd_a == lvl) begin
      pv = lvl + ORD_W'(1);
    end else if ($signed(cur) > $signed(rd_a)) begin
      pv = cur;
    end else begin
      pv = rd_a;
    end
  end

  always_comb begin
    we = 1'b0;
    wa = idx;
    wd = '1;
    addr_a = idx;
    addr_b = idx;
    idx_next = idx;
    lvl_next = lvl;
    cur_next = cur;
    ord_next = ord;
    res_node_next = res_node;
    res_status_next = res_status;
    stat = '0;
    stat.clear_last = (clr_idx == IW'(NODES - 1));
    stat.range_bad = (tgt == IW'(NODES));
    mk_en = 1'b0;
    mk_node = idx;
    mk_val = '1;
    mk_lvl = lvl;
    step_node = idx;
    unique case (cmd)
      CMD_CLEAR: begin
        we = 1'b1;
        wa = clr_idx;
        wd = clr_lvl;
      end
      CMD_LOAD: begin
        addr_a = tgt;
        idx_next = tgt;
        ord_next = block_order;
        lvl_next = level_of(tgt);
        res_node_next = '0;
        if (stat.range_bad) begin
          res_status_next = operation ? ST_NOT_ALLOC : ST_NO_BLOCK;
        end else begin
          res_status_next = ST_OK;
        end
      end
      CMD_ROOT_CHK: begin
        if (!fits(rd_a, ord_s)) begin
          stat.finish = 1'b1;
          res_status_next = ST_NO_BLOCK;
        end else if (is_leaf(idx)) begin
          mk_en = 1'b1;
        end else begin
          addr_a = lc_of(idx);
          addr_b = rc_of(idx);
        end
      end
      CMD_DESC_STEP: begin
        if (fits(rd_a, ord_s) || fits(rd_b, ord_s)) begin
          step_node = fits(rd_a, ord_s) ? lc_of(idx) : rc_of(idx);
          if (is_leaf(step_node)) begin
            mk_en = 1'b1;
            mk_node = step_node;
            mk_lvl = lvl - ORD_W'(1);
          end else begin
            idx_next = step_node;
            lvl_next = lvl - ORD_W'(1);
            addr_a = lc_of(step_node);
            addr_b = rc_of(step_node);
          end
        end else begin
          mk_en = 1'b1;
        end
      end
      CMD_FREE_CHK: begin
        if (rd_a != '1) begin
          stat.finish = 1'b1;
          res_status_next = ST_NOT_ALLOC;
        end else begin
          mk_en = 1'b1;
          mk_val = lvl;
        end
      end
      CMD_WALK_STEP: begin
        if (pv == rd_b) begin
          stat.finish = 1'b1;
        end else begin
          we = 1'b1;
          wa = par_node;
          wd = pv;
          idx_next = par_node;
          cur_next = pv;
          lvl_next = lvl + ORD_W'(1);
          addr_a = sib_of(par_node);
          addr_b = par_of(par_node);
          stat.finish = (par_node == '0);
        end
      end
      CMD_NOP, CMD_EMIT: begin
      end
      default: begin
      end
    endcase
    if (mk_en) begin
      we = 1'b1;
      wa = mk_node;
      wd = mk_val;
      idx_next = mk_node;
      cur_next = mk_val;
      lvl_next = mk_lvl;
      res_node_next = mk_node;
      addr_a = sib_of(mk_node);
      addr_b = par_of(mk_node);
      stat.finish = (mk_node == '0);
      stat.walk = (mk_node != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      clr_bound <= '0;
      clr_lvl <= ORD_W'(MAX_ORDER);
    end else if (cmd == CMD_CLEAR) begin
      clr_idx <= clr_idx + IW'(1);
      if (clr_idx == clr_bound) begin
        clr_lvl <= clr_lvl - ORD_W'(1);
        clr_bound <= IW'({clr_bound, 1'b0} + (IW + 1)'(2));
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    lvl <= lvl_next;
    cur <= cur_next;
    ord <= ord_next;
    res_node <= res_node_next;
    res_status <= res_status_next;
    if (cmd == CMD_EMIT) begin
      node_q <= res_node;
      status_q <= res_status;
    end
  end

  assign node_index = node_q;
  assign status = status_q;

endmodule

>>> sim/buddy_tree_checker.sv
`timescale 1ns / 100ps
// Checker for the buddy tree allocator: mirrors the tree, predicts each reply word and compares.
module buddy_tree_checker
  import bta_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic        operation,
  input  logic [10:0] search_root,
  input  logic [3:0]  block_order,
  input  logic [10:0] free_node,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  logic [10:0] node_index,
  input  logic [1:0]  status,
  output int          mismatches,
  output int          outstanding
);

  localparam int TOP_ORDER = 10;
  localparam int NODES = (2 << TOP_ORDER) - 1;

  typedef struct packed {
    logic [10:0] node;
    status_t     st;
  } reply_t;

  logic signed [ORD_W-1:0] free_order [NODES];
  reply_t awaited_replies [$];
  reply_t want;

  function automatic int level_of(int idx);
    int v;
    int d;
    v = idx + 1;
    d = 0;
    while (v > 1) begin
      v = v >> 1;
      d++;
    end
    return TOP_ORDER - d;
  endfunction

  function automatic void clear_tree();
    for (int i = 0; i < NODES; i++) begin
      free_order[i] = ORD_W'(level_of(i));
    end
  endfunction

  // Recompute parents until one keeps its value; two whole free buddies merge.
  function automatic void merge_upward(int start);
    int idx;
    int lvl;
    int sib;
    int par;
    int cur;
    int sv;
    int pv;
    idx = start;
    lvl = level_of(idx);
    while (idx != 0) begin
      sib = (idx % 2 == 1) ? idx + 1 : idx - 1;
      par = (idx - 1) >> 1;
      cur = int'(free_order[idx]);
      sv = int'(free_order[sib]);
      if (cur == lvl && sv == lvl) begin
        pv = lvl + 1;
      end else begin
        pv = (cur > sv) ? cur : sv;
      end
      if (pv == int'(free_order[par])) break;
      free_order[par] = ORD_W'(pv);
      idx = par;
      lvl++;
    end
  endfunction

  function automatic reply_t serve_request(logic op, int root, int ord, int fnode);
    reply_t r;
    int idx;
    int lc;
    int rc;
    r.node = '0;
    r.st = ST_OK;
    if (op == OP_ALLOC) begin
      if (root >= NODES || int'(free_order[root]) < ord) begin
        r.st = ST_NO_BLOCK;
        return r;
      end
      idx = root;
      while (1'b1) begin
        lc = 2 * idx + 1;
        rc = 2 * idx + 2;
        if (int'(free_order[idx]) < ord || rc >= NODES) break;
        if (int'(free_order[lc]) >= ord) begin
          idx = lc;
        end else if (int'(free_order[rc]) >= ord) begin
          idx = rc;
        end else begin
          break;
        end
      end
      free_order[idx] = ORD_W'(-1);
      merge_upward(idx);
      r.node = idx[10:0];
    end else begin
      if (fnode >= NODES || int'(free_order[fnode]) != -1) begin
        r.st = ST_NOT_ALLOC;
        return r;
      end
      free_order[fnode] = ORD_W'(level_of(fnode));
      merge_upward(fnode);
      r.node = fnode[10:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_tree();
      awaited_replies.delete();
      mismatches = 0;
    end else begin
      if (req_valid && req_ready) begin
        awaited_replies.push_back(serve_request(operation, int'(search_root),
                                                int'(block_order), int'(free_node)));
      end
      if (rsp_valid && rsp_ready) begin
        if (awaited_replies.size() == 0) begin
          mismatches++;
          $display("%0t: reply word with none expected, node_index %0d status %0d",
                   $time, node_index, status);
        end else begin
          want = awaited_replies.pop_front();
          if (node_index !== want.node) begin
            mismatches++;
            $display("%0t: node_index expected %0d got %0d", $time, want.node, node_index);
          end
          if (status !== want.st) begin
            mismatches++;
            $display("%0t: status expected %0d got %0d", $time, want.st, status);
          end
        end
      end
    end
    outstanding = awaited_replies.size();
  end

endmodule

>>> sim/tb_buddy_tree_allocator.sv
`timescale 1ns / 100ps
// Testbench top for the buddy tree allocator: clock, reset, request stimulus and verdict.
module tb_buddy_tree_allocator
  import bta_pkg::*;
();

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_WORDS = 700;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic        operation = OP_ALLOC;
  logic [10:0] search_root = '0;
  logic [3:0]  block_order = '0;
  logic [10:0] free_node = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [10:0] node_index;
  logic [1:0]  status;

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int handed_out = 0;
  int released = 0;
  int refused = 0;
  logic sent_ops [$];
  int live_blocks [$];

  buddy_tree_allocator dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .operation  (operation),
    .search_root(search_root),
    .block_order(block_order),
    .free_node  (free_node),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .node_index (node_index),
    .status     (status)
  );

  buddy_tree_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .operation  (operation),
    .search_root(search_root),
    .block_order(block_order),
    .free_node  (free_node),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .node_index (node_index),
    .status     (status),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
  end

  // Blocks that come back allocated become candidates for well-formed frees.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready && sent_ops.size() > 0) begin
      if (sent_ops.pop_front() == OP_ALLOC && status == ST_OK) begin
        live_blocks.push_back(int'(node_index));
        handed_out++;
      end else if (status == ST_OK) begin
        released++;
      end else begin
        refused++;
      end
    end
  end

  task automatic send_word(input logic op, input int root, input int ord, input int fnode);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    search_root <= root[10:0];
    block_order <= ord[3:0];
    free_node <= fnode[10:0];
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent_ops.push_back(op);
  endtask

  task automatic send_random_word();
    int pick;
    int k;
    int root;
    int ord;
    pick = $urandom_range(0, 99);
    if (pick >= 45 && pick < 85 && live_blocks.size() > 0) begin
      k = $urandom_range(0, live_blocks.size() - 1);
      send_word(OP_FREE, $urandom_range(0, 2047), $urandom_range(0, 15), live_blocks[k]);
      live_blocks.delete(k);
    end else if (pick >= 85) begin
      if ($urandom_range(0, 1) == 0) begin
        send_word(OP_FREE, $urandom_range(0, 2047), $urandom_range(0, 15),
                  $urandom_range(0, 2047));
      end else begin
        send_word(OP_ALLOC, $urandom_range(0, 2047), $urandom_range(0, 15),
                  $urandom_range(0, 2047));
      end
    end else begin
      root = 0;
      if ($urandom_range(0, 3) == 0 && live_blocks.size() > 0) begin
        root = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
        if (root < 1023) root = 2 * root + 1 + $urandom_range(0, 1);
      end else if ($urandom_range(0, 2) == 0) begin
        root = $urandom_range(0, 2046);
      end
      ord = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
      send_word(OP_ALLOC, root, ord, $urandom_range(0, 2047));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Whole pool, refusals, frees of free or out-of-range nodes, leaves, nested searches.
    send_word(OP_ALLOC, 0, 10, 0);
    send_word(OP_ALLOC, 0, 0, 0);
    send_word(OP_FREE, 0, 0, 5);
    send_word(OP_FREE, 0, 0, 0);
    send_word(OP_FREE, 0, 0, 0);
    send_word(OP_ALLOC, 2047, 0, 0);
    send_word(OP_ALLOC, 0, 11, 0);
    send_word(OP_ALLOC, 0, 15, 2047);
    send_word(OP_ALLOC, 0, 0, 0);
    send_word(OP_ALLOC, 2046, 0, 0);
    send_word(OP_ALLOC, 1023, 0, 0);
    send_word(OP_FREE, 0, 0, 2047);
    send_word(OP_ALLOC, 0, 3, 0);
    send_word(OP_ALLOC, 1, 9, 0);
    send_word(OP_ALLOC, 0, 9, 0);
    send_word(OP_ALLOC, 257, 2, 0);
    send_word(OP_ALLOC, 128, 1, 0);
    send_word(OP_FREE, 0, 0, 128);
    send_word(OP_FREE, 0, 0, 257);
    send_word(OP_FREE, 0, 0, 1023);
    send_word(OP_FREE, 0, 0, 2046);
    send_word(OP_FREE, 0, 0, 1);
    send_word(OP_ALLOC, 0, 10, 0);
    send_word(OP_FREE, 0, 0, 0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; stall_pct <= 0; end
        1: begin send_idle_pct = 80; stall_pct <= 0; end
        2: begin send_idle_pct = 0; stall_pct <= 80; end
        default: begin send_idle_pct = 19; stall_pct <= 19; end
      endcase
      for (int i = 0; i < RANDOM_WORDS / 4; i++) send_random_word();
    end
    req_valid <= 1'b0;
    @(posedge clk);

    while (outstanding != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Run covered %0d request words: %0d blocks handed out, %0d released,",
             handed_out + released + refused, handed_out, released);
    $display("and %0d refused, under four idle and stall mixes.", refused);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/bta_pkg.sv
rtl/core/bta_ctrl.sv
rtl/core/bta_datapath.sv
rtl/core/buddy_tree_allocator.sv
sim/buddy_tree_checker.sv
sim/tb_buddy_tree_allocator.sv
